/* rtl/grmmf_pkg.sv */
// Shared types and constants for the gyro rate median and mean filter.
package grmmf_pkg;

  localparam int RAW_W     = 16;
  localparam int BIAS_W    = 20;
  localparam int GAIN_W    = 24;
  localparam int OUT_W     = 24;
  localparam int CORR_W    = 21;
  localparam int MED_W     = 22;
  localparam int ALU_W     = 22;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int ROUND_SH  = 21;
  localparam int PROD_W    = MED_W + GAIN_W + 1;
  localparam int SCL_W     = PROD_W - ROUND_SH;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd1144445;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_READY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_BIAS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MED_LOAD,
    ST_MED_CMP,
    ST_MEAN,
    ST_DIV,
    ST_MUL,
    ST_SCALE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [ALU_W-1:0] diff;
    logic                    neg;
    logic                    zero;
  } alu_res_t;

endpackage

/* rtl/grmmf_sub_unit.sv */
// Shared subtract unit: difference with sign and zero flags for compares and divide steps.
module grmmf_sub_unit (
  input  logic signed [grmmf_pkg::ALU_W-1:0] a_i,
  input  logic signed [grmmf_pkg::ALU_W-1:0] b_i,
  output grmmf_pkg::alu_res_t                res_o
);

  logic signed [grmmf_pkg::ALU_W:0] diff_wide;

  assign diff_wide  = {a_i[grmmf_pkg::ALU_W-1], a_i} - {b_i[grmmf_pkg::ALU_W-1], b_i};
  assign res_o.diff = diff_wide[grmmf_pkg::ALU_W-1:0];
  assign res_o.neg  = diff_wide[grmmf_pkg::ALU_W];
  assign res_o.zero = (diff_wide == '0);

endmodule

/* rtl/gyro_rate_median_mean_filter.sv */
// Top level of the gyro rate filter: bias removal, median, moving mean and gain scaling.
//
// Input channel s_axis: one gyro sample per transfer, tdata = raw_rate, tuser = sample_ok.
// Output channel m_axis: exactly one result per input transfer, tdata = filtered_rate,
// tuser = read_ok. Results leave in input order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i (0 device_ready,
// 1 rate_bias, 2 rate_gain); other indexes are ignored. Write only while idle.
// A held sample (sample_ok low or device not ready) repeats the last output with
// read_ok low and goes straight from idle to the output load state, which fills the output register.
// A new sample runs median ranking over the n filled median entries (n up to
// MEDIAN_DEPTH) on the shared subtract unit, then the mean window update, then restoring
// division by the mean fill count on the same unit, then gain multiply, rounding
// and output load into the output register.
// One sample is in work at a time; s_axis_tready is high only while the sequencer idles.
// The output register holds a finished result until m_axis_tready takes it; a new
// sample may be accepted meanwhile, and its result waits for the register to free.
// Reset clears the fill counts, the last output and the registers to their defaults;
// window contents are only read once written, so they need no clearing.
module gyro_rate_median_mean_filter #(
  parameter int MEDIAN_DEPTH = 4,
  parameter int MEAN_DEPTH   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [grmmf_pkg::RAW_W-1:0]       s_axis_tdata,   // [15:0] raw_rate
  input  logic [0:0]                        s_axis_tuser,   // [0] sample_ok
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [grmmf_pkg::OUT_W-1:0]       m_axis_tdata,   // [23:0] filtered_rate
  output logic [0:0]                        m_axis_tuser,   // [0] read_ok
  input  logic                              cfg_we_i,
  input  logic [grmmf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [grmmf_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int MED_IW  = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
  localparam int MED_NW  = $clog2(MEDIAN_DEPTH + 1);
  localparam int MEAN_IW = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
  localparam int MEAN_NW = $clog2(MEAN_DEPTH + 1);
  localparam int SUM_W   = grmmf_pkg::MED_W + $clog2(MEAN_DEPTH);
  localparam int DIV_CW  = $clog2(grmmf_pkg::MED_W);

  localparam int CORR_W = grmmf_pkg::CORR_W;
  localparam int MED_W  = grmmf_pkg::MED_W;
  localparam int ALU_W  = grmmf_pkg::ALU_W;
  localparam int OUT_W  = grmmf_pkg::OUT_W;

  grmmf_pkg::state_e state_q, state_d;

  // configuration
  logic                                    dev_ready_q;
  logic signed [grmmf_pkg::BIAS_W-1:0]     bias_q;
  logic        [grmmf_pkg::GAIN_W-1:0]     gain_q;

  // median window
  logic signed [CORR_W-1:0] med_win_q [MEDIAN_DEPTH];
  logic [MED_IW-1:0]        med_widx_q;
  logic                     med_filled_q;
  logic [MED_NW-1:0]        med_n_q;
  logic [MED_IW-1:0]        med_i_q, med_j_q, rank_q;
  logic signed [CORR_W-1:0] cand_q;
  logic signed [CORR_W-1:0] lo_q, hi_q;

  // mean window
  logic signed [MED_W-1:0]  mean_win_q [MEAN_DEPTH];
  logic [MEAN_IW-1:0]       mean_widx_q;
  logic                     mean_filled_q;
  logic [MEAN_NW-1:0]       mean_n_q;
  logic signed [SUM_W-1:0]  sum_q;

  // divider and scaling
  logic [MEAN_NW-1:0]                     rem_q;
  logic [MED_W-1:0]                       dq_q;
  logic [DIV_CW-1:0]                      div_cnt_q;
  logic                                   mean_neg_q;
  logic signed [grmmf_pkg::PROD_W-1:0]    prod_q;
  logic signed [OUT_W-1:0]                last_q;
  logic                                   ok_q;

  // output register
  logic                     m_valid_q;
  logic [OUT_W-1:0]         m_data_q;
  logic                     m_user_q;

  // shared unit
  logic signed [ALU_W-1:0]  alu_a, alu_b;
  grmmf_pkg::alu_res_t      alu_res;

  grmmf_sub_unit u_sub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_ready_q <= 1'b0;
      bias_q      <= '0;
      gain_q      <= grmmf_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        grmmf_pkg::REG_DEVICE_READY: dev_ready_q <= cfg_data_i[0];
        grmmf_pkg::REG_RATE_BIAS:    bias_q      <= cfg_data_i[grmmf_pkg::BIAS_W-1:0];
        grmmf_pkg::REG_RATE_GAIN:    gain_q      <= cfg_data_i[grmmf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // bias removal and saturation
  logic signed [MED_W-1:0]  corr_wide;
  logic signed [CORR_W-1:0] corr;
  logic                     take_in, take_ok;

  assign corr_wide = {{(MED_W - grmmf_pkg::RAW_W - 4){s_axis_tdata[grmmf_pkg::RAW_W-1]}},
                      s_axis_tdata, 4'b0000}
                   - {{(MED_W - grmmf_pkg::BIAS_W){bias_q[grmmf_pkg::BIAS_W-1]}}, bias_q};

  always_comb begin
    if (corr_wide[MED_W-1] != corr_wide[MED_W-2]) begin
      corr = corr_wide[MED_W-1] ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}};
    end else begin
      corr = corr_wide[CORR_W-1:0];
    end
  end

  assign take_in = (state_q == grmmf_pkg::ST_IDLE) && s_axis_tvalid;
  assign take_ok = s_axis_tuser[0] & dev_ready_q;

  // median window push
  logic              med_wrap;
  logic [MED_IW-1:0] med_widx_nx;
  logic              med_filled_nx;
  logic [MED_NW-1:0] med_n_nx;

  assign med_wrap      = (med_widx_q == MED_IW'(MEDIAN_DEPTH - 1));
  assign med_widx_nx   = med_wrap ? '0 : med_widx_q + 1'b1;
  assign med_filled_nx = med_filled_q | med_wrap;
  assign med_n_nx      = med_filled_nx ? MED_NW'(MEDIAN_DEPTH) : MED_NW'(med_widx_q) + 1'b1;

  // median ranking
  logic [MED_IW-1:0]        rd_idx;
  logic signed [CORR_W-1:0] rd_val;
  logic                     less;
  logic [MED_NW-1:0]        rank_fin, half;
  logic                     hit_hi, hit_lo, last_j, last_i;

  assign rd_idx   = (state_q == grmmf_pkg::ST_MED_LOAD) ? med_i_q : med_j_q;
  assign rd_val   = med_win_q[rd_idx];
  assign less     = alu_res.neg | (alu_res.zero & (med_j_q < med_i_q));
  assign rank_fin = MED_NW'(rank_q) + MED_NW'(less);
  assign half     = med_n_q >> 1;
  assign hit_hi   = (rank_fin == half);
  assign hit_lo   = med_n_q[0] ? hit_hi : (rank_fin == half - 1'b1);
  assign last_j   = (MED_NW'(med_j_q) == med_n_q - 1'b1);
  assign last_i   = (MED_NW'(med_i_q) == med_n_q - 1'b1);

  // mean window update
  logic signed [MED_W-1:0]  med_val, old_val;
  logic signed [SUM_W-1:0]  sum_d, u_val;
  logic                     mean_wrap, mean_filled_nx;
  logic [MEAN_IW-1:0]       mean_widx_nx;
  logic [MEAN_NW-1:0]       mean_n_nx;

  assign med_val        = MED_W'(lo_q) + MED_W'(hi_q);
  assign old_val        = mean_win_q[mean_widx_q];
  assign sum_d          = sum_q + SUM_W'(med_val) - (mean_filled_q ? SUM_W'(old_val) : '0);
  assign u_val          = sum_d[SUM_W-1] ? ~sum_d : sum_d;
  assign mean_wrap      = (mean_widx_q == MEAN_IW'(MEAN_DEPTH - 1));
  assign mean_widx_nx   = mean_wrap ? '0 : mean_widx_q + 1'b1;
  assign mean_filled_nx = mean_filled_q | mean_wrap;
  assign mean_n_nx      = mean_filled_nx ? MEAN_NW'(MEAN_DEPTH)
                                         : MEAN_NW'(mean_widx_q) + 1'b1;

  // divide step
  logic [MEAN_NW:0] trial;
  logic             div_last;

  assign trial    = {rem_q, dq_q[MED_W-1]};
  assign div_last = (div_cnt_q == DIV_CW'(MED_W - 1));

  always_comb begin
    if (state_q == grmmf_pkg::ST_DIV) begin
      alu_a = {{(ALU_W - MEAN_NW - 1){1'b0}}, trial};
      alu_b = {{(ALU_W - MEAN_NW){1'b0}}, mean_n_q};
    end else begin
      alu_a = {{(ALU_W - CORR_W){rd_val[CORR_W-1]}}, rd_val};
      alu_b = {{(ALU_W - CORR_W){cand_q[CORR_W-1]}}, cand_q};
    end
  end

  // gain and rounding
  logic signed [MED_W-1:0]                mean_val;
  logic signed [grmmf_pkg::PROD_W-1:0]    rnd;
  logic signed [grmmf_pkg::SCL_W-1:0]     scl;
  logic signed [OUT_W-1:0]                y_sat;

  assign mean_val = mean_neg_q ? ~dq_q : dq_q;
  assign rnd      = prod_q + (grmmf_pkg::PROD_W'(1) << (grmmf_pkg::ROUND_SH - 1));
  assign scl      = rnd[grmmf_pkg::PROD_W-1:grmmf_pkg::ROUND_SH];

  always_comb begin
    if (scl[grmmf_pkg::SCL_W-1:OUT_W-1] != {(grmmf_pkg::SCL_W - OUT_W + 1){1'b0}} &&
        scl[grmmf_pkg::SCL_W-1:OUT_W-1] != {(grmmf_pkg::SCL_W - OUT_W + 1){1'b1}}) begin
      y_sat = scl[grmmf_pkg::SCL_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      y_sat = scl[OUT_W-1:0];
    end
  end

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grmmf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grmmf_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = take_ok ? grmmf_pkg::ST_MED_LOAD : grmmf_pkg::ST_OUT;
        end
      end
      grmmf_pkg::ST_MED_LOAD: state_d = grmmf_pkg::ST_MED_CMP;
      grmmf_pkg::ST_MED_CMP: begin
        if (last_j) begin
          state_d = last_i ? grmmf_pkg::ST_MEAN : grmmf_pkg::ST_MED_LOAD;
        end
      end
      grmmf_pkg::ST_MEAN: state_d = grmmf_pkg::ST_DIV;
      grmmf_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = grmmf_pkg::ST_MUL;
        end
      end
      grmmf_pkg::ST_MUL:   state_d = grmmf_pkg::ST_SCALE;
      grmmf_pkg::ST_SCALE: state_d = grmmf_pkg::ST_OUT;
      grmmf_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = grmmf_pkg::ST_IDLE;
        end
      end
      default: state_d = grmmf_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      med_widx_q    <= '0;
      med_filled_q  <= 1'b0;
      mean_widx_q   <= '0;
      mean_filled_q <= 1'b0;
      sum_q         <= '0;
      last_q        <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      if (take_in && take_ok) begin
        med_widx_q   <= med_widx_nx;
        med_filled_q <= med_filled_nx;
      end
      if (state_q == grmmf_pkg::ST_MEAN) begin
        mean_widx_q   <= mean_widx_nx;
        mean_filled_q <= mean_filled_nx;
        sum_q         <= sum_d;
      end
      if (state_q == grmmf_pkg::ST_SCALE) begin
        last_q <= y_sat;
      end
      if (state_q == grmmf_pkg::ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      ok_q <= take_ok;
      if (take_ok) begin
        med_win_q[med_widx_q] <= corr;
        med_n_q               <= med_n_nx;
        med_i_q               <= '0;
      end
    end
    unique case (state_q)
      grmmf_pkg::ST_MED_LOAD: begin
        cand_q  <= rd_val;
        med_j_q <= '0;
        rank_q  <= '0;
      end
      grmmf_pkg::ST_MED_CMP: begin
        rank_q <= rank_fin[MED_IW-1:0];
        if (last_j) begin
          if (hit_hi) hi_q <= cand_q;
          if (hit_lo) lo_q <= cand_q;
          med_i_q <= med_i_q + 1'b1;
        end else begin
          med_j_q <= med_j_q + 1'b1;
        end
      end
      grmmf_pkg::ST_MEAN: begin
        mean_win_q[mean_widx_q] <= med_val;
        mean_n_q   <= mean_n_nx;
        mean_neg_q <= sum_d[SUM_W-1];
        rem_q      <= MEAN_NW'(u_val >> MED_W);
        dq_q       <= u_val[MED_W-1:0];
        div_cnt_q  <= '0;
      end
      grmmf_pkg::ST_DIV: begin
        rem_q     <= alu_res.neg ? trial[MEAN_NW-1:0] : alu_res.diff[MEAN_NW-1:0];
        dq_q      <= {dq_q[MED_W-2:0], ~alu_res.neg};
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      grmmf_pkg::ST_MUL: begin
        prod_q <= mean_val * $signed({1'b0, gain_q});
      end
      grmmf_pkg::ST_OUT: begin
        if (out_free) begin
          m_data_q <= last_q;
          m_user_q <= ok_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready   = (state_q == grmmf_pkg::ST_IDLE);
  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

endmodule
